@@ rtl/core/cemt_pkg.sv @@
// Package for the CAN encoder multi-turn tracker.
// Holds the frame codes, status codes, queue entry and configuration types.
// No dependencies; the top unit, the front and the back import it.
package cemt_pkg;

  localparam int unsigned SETTING_COUNT = 10;
  localparam int unsigned SET_IDX_W     = $clog2(SETTING_COUNT);

  // Frame classification shown on the result channel.
  typedef enum logic [1:0] {
    KIND_IGNORED  = 2'd0,
    KIND_POSITION = 2'd1,
    KIND_ACK      = 2'd2,
    KIND_CMD      = 2'd3
  } frame_kind_t;

  // Per-setting status codes.
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_SUCCESS = 2'd2;
  localparam logic [1:0] ST_FAIL    = 2'd3;

  // Frame bytes with a fixed meaning.
  localparam logic [7:0] LEN_POSITION    = 8'h07;
  localparam logic [7:0] LEN_ACK         = 8'h04;
  localparam logic [7:0] ACK_MARKER      = 8'h01;
  localparam logic [7:0] ADDR_ACK_MARKER = 8'h08;

  // Function codes of the encoder protocol.
  localparam logic [7:0] FUNC_READ     = 8'h01;
  localparam logic [7:0] FUNC_ADDR     = 8'h02;
  localparam logic [7:0] FUNC_BAUD     = 8'h03;
  localparam logic [7:0] FUNC_MODE     = 8'h04;
  localparam logic [7:0] FUNC_AUTOTIME = 8'h05;
  localparam logic [7:0] FUNC_ZERO     = 8'h06;
  localparam logic [7:0] FUNC_DIR      = 8'h07;
  localparam logic [7:0] FUNC_MID      = 8'h0C;
  localparam logic [7:0] FUNC_LOCATION = 8'h0D;
  localparam logic [7:0] FUNC_FIVETURN = 8'h0F;

  localparam logic [SET_IDX_W-1:0] SET_READ    = SET_IDX_W'(0);
  localparam logic [SET_IDX_W-1:0] SET_ADDR    = SET_IDX_W'(1);
  localparam logic [SET_IDX_W-1:0] NO_SETTING  = '1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_WRAP_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_TURN_SPAN      = 2'd2;

  localparam logic [7:0]  RESET_DEVICE_ADDRESS = 8'd1;
  localparam logic [23:0] RESET_WRAP_THRESHOLD = 24'd2000000;
  localparam logic [23:0] RESET_TURN_SPAN      = 24'd786432;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [23:0] wrap_threshold;
    logic [23:0] turn_span;
  } cfg_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    frame_kind_t          kind;
    logic [SET_IDX_W-1:0] idx;
    logic                 ack_ok;
    logic [23:0]          angle;
  } item_t;

  function automatic logic [SET_IDX_W-1:0] code_to_setting(input logic [7:0] code);
    logic [SET_IDX_W-1:0] idx;
    case (code)
      FUNC_READ:     idx = SET_IDX_W'(0);
      FUNC_ADDR:     idx = SET_IDX_W'(1);
      FUNC_BAUD:     idx = SET_IDX_W'(2);
      FUNC_MODE:     idx = SET_IDX_W'(3);
      FUNC_AUTOTIME: idx = SET_IDX_W'(4);
      FUNC_ZERO:     idx = SET_IDX_W'(5);
      FUNC_DIR:      idx = SET_IDX_W'(6);
      FUNC_MID:      idx = SET_IDX_W'(7);
      FUNC_LOCATION: idx = SET_IDX_W'(8);
      FUNC_FIVETURN: idx = SET_IDX_W'(9);
      default:       idx = NO_SETTING;
    endcase
    return idx;
  endfunction

endpackage

@@ rtl/core/cemt_chan_if.sv @@
// Channel interfaces of the CAN encoder multi-turn tracker.
// cemt_in_if carries input words, cemt_out_if carries result words; no dependencies.
interface cemt_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] length_byte;
  logic [7:0] addr_byte;
  logic [7:0] func_byte;
  logic [7:0] data_low;
  logic [7:0] data_mid;
  logic [7:0] data_high;

  modport source (output valid, req_type, length_byte, addr_byte, func_byte,
                  data_low, data_mid, data_high, input ready);
  modport sink (input valid, req_type, length_byte, addr_byte, func_byte,
                data_low, data_mid, data_high, output ready);
endinterface

interface cemt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] total_angle;
  logic signed [15:0] turn_total;
  logic        [23:0] raw_angle;
  logic        [1:0]  frame_kind;
  logic        [3:0]  setting_index;
  logic        [1:0]  setting_state;

  modport source (output valid, total_angle, turn_total, raw_angle, frame_kind,
                  setting_index, setting_state, input ready);
  modport sink (input valid, total_angle, turn_total, raw_angle, frame_kind,
                setting_index, setting_state, output ready);
endinterface

@@ rtl/core/can_encoder_frame_multiturn_tracker_unit.sv @@
// Multi-turn tracker for a CAN absolute encoder.
// Holds the configuration registers and joins the front and the back.
//
// in_chan carries one word per received encoder frame, or a note that a setting
// command was sent (req_type high). out_chan gives exactly one result word per
// input word, in order: the multi-turn total, the turn count, the last angle,
// the frame classification and the status of the setting the word touched.
// cfg_we writes register cfg_index (0 device address, 1 wrap threshold,
// 2 turn span) from cfg_wdata; other indexes are dropped. Write only while idle.
//
// Throughput is one word per cycle while out_chan is not stalled. A word is written
// into the input queue, then passes the execute, multiply and add/saturate
// registers before its result is valid on out_chan.
// When out_chan stalls, the back pipeline holds and the input queue of
// QUEUE_DEPTH entries absorbs words until it is full, then in_chan.ready drops.
// Synchronous reset restores the registers, clears the turn count, angle and total
// and returns every setting status to idle.
module can_encoder_frame_multiturn_tracker_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  cemt_in_if.sink     in_chan,
  cemt_out_if.source  out_chan
);
  import cemt_pkg::*;

  cfg_t  cfg_r;
  item_t head;
  logic  head_valid;
  logic  pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= RESET_DEVICE_ADDRESS;
      cfg_r.wrap_threshold <= RESET_WRAP_THRESHOLD;
      cfg_r.turn_span      <= RESET_TURN_SPAN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_wdata[7:0];
        CFG_WRAP_THRESHOLD: cfg_r.wrap_threshold <= cfg_wdata;
        CFG_TURN_SPAN:      cfg_r.turn_span      <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  cemt_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .device_address (cfg_r.device_address),
    .in_chan        (in_chan),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop)
  );

  cemt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

@@ rtl/core/cemt_front.sv @@
// Front of the tracker: classifies each input word and queues it for the back.
// Depends on cemt_pkg and cemt_in_if.
module cemt_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      device_address,
  cemt_in_if.sink         in_chan,
  output cemt_pkg::item_t head,
  output logic            head_valid,
  input  logic            pop
);
  import cemt_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t                q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 push;
  logic [SET_IDX_W-1:0] map_idx;
  logic [7:0]           marker;
  item_t                cls;

  always_comb begin
    map_idx    = code_to_setting(in_chan.func_byte);
    marker     = (map_idx == SET_ADDR) ? ADDR_ACK_MARKER : ACK_MARKER;
    cls.kind   = KIND_IGNORED;
    cls.ack_ok = (in_chan.data_low != 8'd0);
    cls.angle  = {in_chan.data_high, in_chan.data_mid, in_chan.data_low};
    if (map_idx != NO_SETTING) begin
      if (in_chan.req_type) begin
        cls.kind = KIND_CMD;
      end else if (map_idx == SET_READ) begin
        if (in_chan.length_byte == LEN_POSITION && in_chan.addr_byte == device_address) begin
          cls.kind = KIND_POSITION;
        end
      end else if (in_chan.length_byte == LEN_ACK && in_chan.addr_byte == marker) begin
        cls.kind = KIND_ACK;
      end
    end
    // Ignored words carry setting zero so the back never looks past the table.
    cls.idx = (cls.kind == KIND_IGNORED) ? SET_READ : map_idx;
  end

  assign in_chan.ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign head          = q_r[rd_ptr_r];
  assign head_valid    = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/core/cemt_back.sv @@
// Back of the tracker: updates setting status and turn count, then forms the total.
// Three register stages: execute, multiply, add with saturation. Depends on cemt_pkg.
module cemt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cemt_pkg::cfg_t  cfg,
  input  cemt_pkg::item_t head,
  input  logic            head_valid,
  output logic            pop,
  cemt_out_if.source      out_chan
);
  import cemt_pkg::*;

  localparam logic signed [41:0] SUM_MAX = 42'sd2147483647;
  localparam logic signed [41:0] SUM_MIN = -42'sd2147483648;

  // Architectural state.
  logic [1:0]         status_r [SETTING_COUNT];
  logic [23:0]        last_angle_r, last_angle_nxt;
  logic signed [15:0] counter_r, counter_nxt;
  logic signed [31:0] total_r;

  // Pipeline registers.
  logic                 en;
  logic                 v1_r, v2_r, out_valid_r;
  frame_kind_t          kind1_r, kind2_r, kind_out_r;
  logic [SET_IDX_W-1:0] idx1_r, idx2_r, idx_out_r;
  logic [1:0]           st1_r, st2_r, st_out_r;
  logic [23:0]          ang1_r, ang2_r, ang_out_r;
  logic signed [15:0]   cnt1_r, cnt2_r, cnt_out_r;
  logic signed [40:0]   prod2_r;
  logic signed [31:0]   total_out_r;

  logic [1:0]         cur_state, new_state, shown_state;
  logic               st_write;
  logic signed [24:0] diff, thr_pos, thr_neg;
  logic signed [40:0] prod;
  logic signed [41:0] sum;
  logic signed [31:0] sat_total, total_pick;

  assign en  = !out_valid_r || out_chan.ready;
  assign pop = head_valid && en;

  always_comb begin
    cur_state = status_r[head.idx];
    new_state = cur_state;
    st_write  = 1'b0;
    case (head.kind)
      KIND_CMD: begin
        new_state = ST_PENDING;
        st_write  = 1'b1;
      end
      KIND_POSITION: begin
        if (cur_state == ST_PENDING) begin
          new_state = ST_SUCCESS;
        end
        st_write = 1'b1;
      end
      KIND_ACK: begin
        new_state = (head.ack_ok && cur_state == ST_PENDING) ? ST_SUCCESS : ST_FAIL;
        st_write  = 1'b1;
      end
      default: begin
        new_state = cur_state;
        st_write  = 1'b0;
      end
    endcase
    shown_state = (head.kind == KIND_IGNORED) ? ST_IDLE : new_state;
  end

  // Turn unwrap: a forward jump past the threshold means the angle wrapped backward.
  always_comb begin
    diff           = $signed({1'b0, head.angle}) - $signed({1'b0, last_angle_r});
    thr_pos        = $signed({1'b0, cfg.wrap_threshold});
    thr_neg        = -thr_pos;
    counter_nxt    = counter_r;
    last_angle_nxt = last_angle_r;
    if (head.kind == KIND_POSITION) begin
      last_angle_nxt = head.angle;
      if (diff > thr_pos) begin
        if (counter_r != 16'sh8000) begin
          counter_nxt = counter_r - 16'sd1;
        end
      end else if (diff < thr_neg) begin
        if (counter_r != 16'sh7FFF) begin
          counter_nxt = counter_r + 16'sd1;
        end
      end
    end
  end

  always_comb begin
    prod      = cnt1_r * $signed({1'b0, cfg.turn_span});
    sum       = $signed({prod2_r[40], prod2_r}) + $signed({18'd0, ang2_r});
    if (sum > SUM_MAX) begin
      sat_total = 32'sh7FFFFFFF;
    end else if (sum < SUM_MIN) begin
      sat_total = 32'sh80000000;
    end else begin
      sat_total = sum[31:0];
    end
    total_pick = (kind2_r == KIND_POSITION) ? sat_total : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SETTING_COUNT; i++) begin
        status_r[i] <= ST_IDLE;
      end
      last_angle_r <= '0;
      counter_r    <= '0;
      total_r      <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        if (st_write) begin
          status_r[head.idx] <= new_state;
        end
        last_angle_r <= last_angle_nxt;
        counter_r    <= counter_nxt;
      end
      if (en) begin
        v1_r        <= pop;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
        if (v2_r) begin
          total_r <= total_pick;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r     <= head.kind;
      idx1_r      <= head.idx;
      st1_r       <= shown_state;
      ang1_r      <= last_angle_nxt;
      cnt1_r      <= counter_nxt;
      kind2_r     <= kind1_r;
      idx2_r      <= idx1_r;
      st2_r       <= st1_r;
      ang2_r      <= ang1_r;
      cnt2_r      <= cnt1_r;
      prod2_r     <= prod;
      kind_out_r  <= kind2_r;
      idx_out_r   <= idx2_r;
      st_out_r    <= st2_r;
      ang_out_r   <= ang2_r;
      cnt_out_r   <= cnt2_r;
      total_out_r <= total_pick;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.total_angle   = total_out_r;
  assign out_chan.turn_total    = cnt_out_r;
  assign out_chan.raw_angle     = ang_out_r;
  assign out_chan.frame_kind    = kind_out_r;
  assign out_chan.setting_index = 4'(idx_out_r);
  assign out_chan.setting_state = st_out_r;

  a_ignored_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_out_r == KIND_IGNORED) |-> (idx_out_r == '0 && st_out_r == ST_IDLE))
    else $error("ignored word shows a setting");

  a_cmd_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_out_r == KIND_CMD) |-> (st_out_r == ST_PENDING))
    else $error("recorded command did not leave its setting pending");

  a_ack_resolved: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_out_r == KIND_ACK) |-> (st_out_r == ST_SUCCESS || st_out_r == ST_FAIL))
    else $error("acknowledge left its setting unresolved");

  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> (counter_r == $past(counter_r)))
    else $error("turn counter moved without a word");

endmodule
